FILE: hdl/swes_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swes_pkg: shared types and constants of the sliding window event statistics
// Holds the store depth, derived widths, command and kind codes, and the word
// types that cross the block's ports and its internal units.
// ----------------------------------------------------------------------------
package swes_pkg;

  // Store geometry.
  localparam int DEPTH  = 1024;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int OCC_W  = $clog2(DEPTH + 1);
  // A latency sum holds at most DEPTH values of 32 bits.
  localparam int SUM_W  = 32 + IDX_W;
  // Rounded dividend is the sum plus half the count, one bit wider.
  localparam int DIVD_W = SUM_W + 1;
  localparam int DCNT_W = $clog2(DIVD_W);

  localparam logic [31:0] WINDOW_RESET = 32'd30000;

  // Command codes.
  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_PRUNE  = 2'd1;
  localparam logic [1:0] CMD_REPORT = 2'd2;

  // Event kinds; the latency kinds have the top bit set.
  localparam logic [1:0] EV_MEM_WR = 2'd0;
  localparam logic [1:0] EV_MEM_RD = 2'd1;
  localparam logic [1:0] EV_LAT_RD = 2'd2;
  localparam logic [1:0] EV_LAT_WR = 2'd3;

  // Report kinds.
  localparam logic [1:0] RPT_MEAN_RD = 2'd0;
  localparam logic [1:0] RPT_MEAN_WR = 2'd1;
  localparam logic [1:0] RPT_CNT_RD  = 2'd2;
  localparam logic [1:0] RPT_CNT_WR  = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] now_ms;
    logic [1:0]  event_kind;
    logic [31:0] event_value;
    logic [1:0]  report_kind;
  } in_word_t;

  typedef struct packed {
    logic [31:0] answer;
    logic        dropped;
  } out_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] stamp;
    logic [31:0] value;
  } entry_t;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [OCC_W-1:0]  divisor;
  } div_req_t;

endpackage : swes_pkg
`default_nettype wire

FILE: hdl/swes_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swes_div: restoring divider, one quotient bit per cycle
// Divides the rounded latency sum by the sample count. Done pulses for one
// cycle once all quotient bits are formed. The divisor must not be zero.
// ----------------------------------------------------------------------------
module swes_div
  import swes_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire div_req_t          req,
  output logic                   done,
  output logic [DIVD_W-1:0]      quotient
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIVD_W-1:0] quo_r, quo_nxt;
  logic [OCC_W-1:0]  rem_r, rem_nxt;
  logic [OCC_W-1:0]  dvs_r, dvs_nxt;
  logic [OCC_W:0]    rem_sh;
  logic              fits;

  always_comb begin
    rem_sh   = {rem_r, quo_r[DIVD_W-1]};
    fits     = rem_sh >= {1'b0, dvs_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DCNT_W'(DIVD_W - 1);
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[DIVD_W-2:0], fits};
      rem_nxt = fits ? OCC_W'(rem_sh - {1'b0, dvs_r}) : OCC_W'(rem_sh);
      cnt_nxt = cnt_r - DCNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule : swes_div
`default_nettype wire

FILE: hdl/sliding_window_event_stats_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_window_event_stats_top: time window event FIFO with statistics
// Keeps up to DEPTH time-stamped events in one on-chip memory and answers
// prune and report commands from running per-kind counts and latency sums.
// ----------------------------------------------------------------------------
// Usage. Commands arrive as words on the in_ channel (valid/ready) and every
// command produces exactly one word on the out_ channel. The window register
// is written through the cfg_ channel, which is always ready; write it only
// while no command is in flight.
// Sequencing. The block works on one command at a time. Add, count report
// and the unused command go straight to the result word. A prune of an
// empty store does too; otherwise it walks the store from the head and pops
// old events until it meets a new one or empties the store: the head entry
// is read from the event memory through a registered read port, and each
// pop issues the read of the next head in the same cycle. A mean report of
// a nonzero count waits for the one-bit-per-cycle divider (43 quotient bits).
// Reset. A synchronous active-low reset empties the FIFO, clears all counts
// and sums and loads the window with 30000 ms. The event memory is not
// cleared; only held entries are ever read.
// Stalls. The result sits in an output register; while out_ready is low the
// next command is still taken and worked on, and its finished result waits in
// a holding register with in_ready low until the output register frees.
// ----------------------------------------------------------------------------
module sliding_window_event_stats_top
  import swes_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_word_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_word_t        out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_PRUNE = 4'b0010,
    ST_DIV   = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // FIFO pointers and running statistics.
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt;
  logic [OCC_W-1:0] occ_r, occ_nxt;
  logic [OCC_W-1:0] cnt_r [4];
  logic [OCC_W-1:0] cnt_nxt [4];
  logic [SUM_W-1:0] sum_r [2];
  logic [SUM_W-1:0] sum_nxt [2];
  logic [31:0]      window_r, window_nxt;

  // Command working registers.
  logic [31:0]      now_r, now_nxt;
  out_word_t        res_r, res_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_data_r, out_data_nxt;

  // Event memory: one write port for add, one read port for the prune walk.
  entry_t           entry_mem_r [DEPTH];
  entry_t           rd_data_r;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t           mem_wdata;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;

  // Divider for the mean latency.
  div_req_t          div_req;
  logic              div_done;
  logic [DIVD_W-1:0] div_quo;

  logic             accept;
  logic             prune_fin;
  logic             is_old;
  logic [32:0]      limit;
  logic [OCC_W-1:0] mean_n;
  logic [IDX_W-1:0] head_inc;
  logic [IDX_W-1:0] tail_inc;

  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] idx);
    return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + IDX_W'(1);
  endfunction

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign head_inc  = next_slot(head_r);
  assign tail_inc  = next_slot(tail_r);

  // An event is old when its stamp plus the window, taken without wrap,
  // falls below the reference time.
  assign limit  = {1'b0, rd_data_r.stamp} + {1'b0, window_r};
  assign is_old = limit < {1'b0, now_r};
  assign mean_n = cnt_r[{1'b1, in_data.report_kind[0]}];

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    occ_nxt       = occ_r;
    cnt_nxt       = cnt_r;
    sum_nxt       = sum_r;
    window_nxt    = window_r;
    now_nxt       = now_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = tail_r;
    mem_wdata     = '{kind: in_data.event_kind, stamp: in_data.now_ms,
                      value: in_data.event_value};
    mem_re        = 1'b0;
    mem_raddr     = head_r;
    div_req       = '{start: 1'b0,
                      dividend: DIVD_W'(sum_r[in_data.report_kind[0]])
                                + DIVD_W'(mean_n >> 1),
                      divisor: mean_n};
    prune_fin     = 1'b0;

    if (cfg_valid && cfg_ready) begin
      window_nxt = cfg_data;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          res_nxt = '0;
          now_nxt = in_data.now_ms;
          state_nxt = ST_DONE;
          unique case (in_data.cmd)
            CMD_ADD: begin
              if (occ_r == OCC_W'(DEPTH)) begin
                res_nxt.dropped = 1'b1;
              end else begin
                mem_we   = 1'b1;
                tail_nxt = tail_inc;
                occ_nxt  = occ_r + OCC_W'(1);
                cnt_nxt[in_data.event_kind] = cnt_r[in_data.event_kind] + OCC_W'(1);
                if (in_data.event_kind[1]) begin
                  sum_nxt[in_data.event_kind[0]] = sum_r[in_data.event_kind[0]]
                                                   + SUM_W'(in_data.event_value);
                end
              end
            end
            CMD_PRUNE: begin
              if (occ_r == '0) begin
                prune_fin = 1'b1;
              end else begin
                mem_re    = 1'b1;
                state_nxt = ST_PRUNE;
              end
            end
            CMD_REPORT: begin
              unique case (in_data.report_kind)
                RPT_CNT_RD: res_nxt.answer = 32'(cnt_r[EV_MEM_RD]);
                RPT_CNT_WR: res_nxt.answer = 32'(cnt_r[EV_MEM_WR]);
                default: begin
                  // Mean of an empty set is zero; otherwise divide.
                  if (mean_n != '0) begin
                    div_req.start = 1'b1;
                    state_nxt     = ST_DIV;
                  end
                end
              endcase
            end
            default: ;
          endcase
        end
      end
      ST_PRUNE: begin
        if (is_old) begin
          cnt_nxt[rd_data_r.kind] = cnt_r[rd_data_r.kind] - OCC_W'(1);
          if (rd_data_r.kind[1]) begin
            sum_nxt[rd_data_r.kind[0]] = sum_r[rd_data_r.kind[0]]
                                         - SUM_W'(rd_data_r.value);
          end
          head_nxt = head_inc;
          occ_nxt  = occ_r - OCC_W'(1);
          if (occ_r == OCC_W'(1)) begin
            prune_fin = 1'b1;
            state_nxt = ST_DONE;
          end else begin
            // Fetch the next head while this one is retired.
            mem_re    = 1'b1;
            mem_raddr = head_inc;
          end
        end else begin
          prune_fin = 1'b1;
          state_nxt = ST_DONE;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          res_nxt.answer = div_quo[31:0];
          state_nxt      = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // The prune answer counts the memory read and write events left after this cycle's pop.
    if (prune_fin) begin
      res_nxt.answer = 32'({1'b0, cnt_nxt[EV_MEM_WR]} + {1'b0, cnt_nxt[EV_MEM_RD]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      occ_r       <= '0;
      cnt_r       <= '{default: '0};
      sum_r       <= '{default: '0};
      window_r    <= WINDOW_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      occ_r       <= occ_nxt;
      cnt_r       <= cnt_nxt;
      sum_r       <= sum_nxt;
      window_r    <= window_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    now_r      <= now_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      entry_mem_r[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data_r <= entry_mem_r[mem_raddr];
    end
  end

  swes_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule : sliding_window_event_stats_top
`default_nettype wire
